>>> src/pqel_pkg.sv
// Package for the power quality event logger: field widths, item kinds,
// register indexes, channel phase codes and the per-lane command struct.
// Used by the lane, merge and core modules; depends on nothing.
package pqel_pkg;

	// Six fault channels: sag A-C, then swell A-C
	localparam int NUM_CH = 6;

	// Defaults for the top-level parameters
	localparam int LOG_DEPTH_DEF  = 8;
	localparam int TIME_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int TS_FIELD_W = 32;
	localparam int HOLD_W     = 8;
	localparam int CNT_W      = 8;
	localparam int FLAGS_W    = 14;
	localparam int QOFF_W     = 4;
	localparam int QCH_W      = 3;

	// Hold counts after reset
	localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd3;

	// Item kinds carried in tuser
	typedef enum logic [1:0] {
		KIND_UPDATE = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic {
		REG_START_HOLD = 1'b0,
		REG_END_HOLD   = 1'b1
	} reg_idx_t;

	// Channel qualification phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_START  = 4'b0010,
		PH_ACTIVE = 4'b0100,
		PH_END    = 4'b1000
	} phase_t;

	// Command broadcast to every lane on an accepted beat
	typedef struct packed {
		logic              update;
		logic              clear;
		logic              query;
		logic [QOFF_W-1:0] qoff;
		logic [HOLD_W-1:0] start_hold;
		logic [HOLD_W-1:0] end_hold;
	} cmd_t;

endpackage

>>> src/pqel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the completed start/end time rows of one channel; no dependencies.
module pqel_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/pqel_lane.sv
// One fault channel: debounce machine, hold counter, log slot, event count,
// current start time and the ring of completed entries (pqel_ram).
// Depends on pqel_pkg and pqel_ram.
module pqel_lane #(
	parameter int LOG_DEPTH  = pqel_pkg::LOG_DEPTH_DEF,
	parameter int TIME_WIDTH = pqel_pkg::TIME_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pqel_pkg::cmd_t               cmd,
	input  logic                         flag,
	input  logic [TIME_WIDTH-1:0]        ts,
	input  logic                         sel,
	output logic                         done,
	output logic [pqel_pkg::CNT_W-1:0]   cnt,
	output logic [TIME_WIDTH-1:0]        cur_start,
	output logic                         ent_valid,
	output logic [2*TIME_WIDTH-1:0]      rdata
);

	localparam int SW = $clog2(LOG_DEPTH);
	localparam int IW = ((SW > pqel_pkg::QOFF_W) ? SW : pqel_pkg::QOFF_W) + 1;

	pqel_pkg::phase_t                phase_q, phase_d;
	logic [pqel_pkg::HOLD_W-1:0]     hold_q, hold_d, hold_m1;
	logic [SW-1:0]                   slot_q, slot_d, slot_nx;
	logic [pqel_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [TIME_WIDTH-1:0]           start_q, start_d;
	logic [LOG_DEPTH-1:0]            valid_q, valid_d;
	logic                            wr_en;
	logic [IW-1:0]                   slot_x, off_x, diff;
	logic [SW-1:0]                   raddr;

	assign hold_m1 = hold_q - 1'b1;
	assign slot_nx = (slot_q == SW'(LOG_DEPTH - 1)) ? '0 : slot_q + 1'b1;

	// Advance the channel machine on update beats
	always_comb begin
		phase_d = phase_q;
		hold_d  = hold_q;
		start_d = start_q;
		wr_en   = 1'b0;
		if (cmd.update) begin
			unique case (phase_q)
				pqel_pkg::PH_IDLE: begin
					if (flag) begin
						phase_d = pqel_pkg::PH_START;
						hold_d  = cmd.start_hold;
					end
				end
				pqel_pkg::PH_START: begin
					if (flag) begin
						hold_d = hold_m1;
						if (hold_m1 == '0) begin
							phase_d = pqel_pkg::PH_ACTIVE;
							start_d = ts;
						end
					end else begin
						phase_d = pqel_pkg::PH_IDLE;
					end
				end
				pqel_pkg::PH_ACTIVE: begin
					if (!flag) begin
						phase_d = pqel_pkg::PH_END;
						hold_d  = cmd.end_hold;
					end
				end
				pqel_pkg::PH_END: begin
					if (!flag) begin
						hold_d = hold_m1;
						if (hold_m1 == '0) begin
							phase_d = pqel_pkg::PH_IDLE;
							wr_en   = 1'b1;
						end
					end else begin
						phase_d = pqel_pkg::PH_ACTIVE;
					end
				end
				default: phase_d = pqel_pkg::PH_IDLE;
			endcase
		end
	end

	// Slot, count and entry valid bits follow a logged event end
	always_comb begin
		slot_d  = slot_q;
		cnt_d   = cnt_q;
		valid_d = valid_q;
		if (wr_en) begin
			slot_d           = slot_nx;
			cnt_d            = cnt_q + 1'b1;
			valid_d[slot_q]  = 1'b1;
			valid_d[slot_nx] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pqel_pkg::PH_IDLE;
			hold_q  <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else if (cmd.clear) begin
			phase_q <= pqel_pkg::PH_IDLE;
			hold_q  <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else begin
			phase_q <= phase_d;
			hold_q  <= hold_d;
			slot_q  <= slot_d;
			cnt_q   <= cnt_d;
			valid_q <= valid_d;
		end
	end

	// Start time of the open event, only meaningful while active or ending
	always_ff @(posedge clk) begin
		start_q <= start_d;
	end

	// Ring index of the queried entry, counting back from the current slot
	always_comb begin
		slot_x = IW'(slot_q);
		off_x  = IW'(cmd.qoff);
		if (slot_x >= off_x) begin
			diff = slot_x - off_x;
		end else begin
			diff = slot_x + IW'(LOG_DEPTH) - off_x;
		end
		raddr = diff[SW-1:0];
	end

	pqel_ram #(
		.WIDTH (2 * TIME_WIDTH),
		.DEPTH (LOG_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_q),
		.wdata ({ts, start_q}),
		.re    (cmd.query & sel),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done      = wr_en;
	assign cnt       = cnt_q;
	assign cur_start = ((phase_q == pqel_pkg::PH_ACTIVE) || (phase_q == pqel_pkg::PH_END)) ?
		start_q : '0;
	assign ent_valid = valid_q[raddr];

endmodule

>>> src/pqel_merge.sv
// Merging stage: registers what the lanes report on an accepted beat and
// picks the queried lane's count and log entry for the result.
// Depends on pqel_pkg.
module pqel_merge #(
	parameter int TIME_WIDTH = pqel_pkg::TIME_WIDTH_DEF
) (
	input  logic                                              clk,
	input  logic                                              load,
	input  logic                                              query,
	input  logic [pqel_pkg::QCH_W-1:0]                        qch,
	input  logic                                              qoff_zero,
	input  logic                                              qoff_ok,
	input  logic [pqel_pkg::NUM_CH-1:0]                       lane_done,
	input  logic [pqel_pkg::NUM_CH-1:0][pqel_pkg::CNT_W-1:0]  lane_cnt,
	input  logic [pqel_pkg::NUM_CH-1:0][TIME_WIDTH-1:0]       lane_cur,
	input  logic [pqel_pkg::NUM_CH-1:0]                       lane_ent_valid,
	input  logic [pqel_pkg::NUM_CH-1:0][2*TIME_WIDTH-1:0]     lane_rdata,
	input  logic [pqel_pkg::FLAGS_W-1:0]                      flags_new,
	output logic [pqel_pkg::NUM_CH-1:0]                       mask,
	output logic [pqel_pkg::FLAGS_W-1:0]                      flags,
	output logic                                              ok,
	output logic [TIME_WIDTH-1:0]                             start_time,
	output logic [TIME_WIDTH-1:0]                             end_time,
	output logic [pqel_pkg::CNT_W-1:0]                        count
);

	logic [pqel_pkg::NUM_CH-1:0]   sel, sel_s1;
	logic                          chan_ok;
	logic [pqel_pkg::CNT_W-1:0]    cnt_sel, cnt_s1;
	logic [TIME_WIDTH-1:0]         cur_sel, cur_s1;
	logic                          ent_sel, ent_s1;
	logic                          ok_s1, cur_pick_s1;
	logic [pqel_pkg::NUM_CH-1:0]   mask_s1;
	logic [pqel_pkg::FLAGS_W-1:0]  flags_s1;
	logic [2*TIME_WIDTH-1:0]       row;

	// Select the queried lane
	always_comb begin
		cnt_sel = '0;
		cur_sel = '0;
		ent_sel = 1'b0;
		for (int i = 0; i < pqel_pkg::NUM_CH; i++) begin
			sel[i] = (qch == pqel_pkg::QCH_W'(i));
			if (sel[i]) begin
				cnt_sel = cnt_sel | lane_cnt[i];
				cur_sel = cur_sel | lane_cur[i];
				ent_sel = ent_sel | lane_ent_valid[i];
			end
		end
		chan_ok = |sel;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sel_s1      <= sel;
			ok_s1       <= query & chan_ok & qoff_ok;
			cur_pick_s1 <= qoff_zero;
			cnt_s1      <= query ? cnt_sel : '0;
			cur_s1      <= cur_sel;
			ent_s1      <= ent_sel;
			mask_s1     <= lane_done;
			flags_s1    <= flags_new;
		end
	end

	// Pick the RAM row of the queried lane
	always_comb begin
		row = '0;
		for (int i = 0; i < pqel_pkg::NUM_CH; i++) begin
			if (sel_s1[i]) begin
				row = row | lane_rdata[i];
			end
		end
	end

	// The current slot comes from the lane registers, older slots from RAM
	always_comb begin
		start_time = '0;
		end_time   = '0;
		if (ok_s1) begin
			if (cur_pick_s1) begin
				start_time = cur_s1;
			end else if (ent_s1) begin
				start_time = row[TIME_WIDTH-1:0];
				end_time   = row[2*TIME_WIDTH-1:TIME_WIDTH];
			end
		end
	end

	assign mask  = mask_s1;
	assign flags = flags_s1;
	assign ok    = ok_s1;
	assign count = cnt_s1;

endmodule

>>> src/power_quality_event_logger_core.sv
// Power quality event logger: six sag/swell channel lanes, merge stage and
// output register. Depends on pqel_pkg, pqel_lane and pqel_merge.
//
// Usage:
//   Input beats on s_* carry the item kind in s_tuser (update, query,
//   clear). Every accepted beat produces exactly one result beat on m_*.
//   An update steps all six channel machines at once and reports the
//   channels whose event end was logged; a query returns the count and one
//   log entry of a channel; a clear zeroes phases, slots, counts and entry valid bits.
//   Throughput is one beat per cycle while m_tready is high: each lane's
//   state updates in the accept cycle, the log RAM read is registered with
//   the merge stage and the merge stage then feeds the output register.
//   While m_tready is low the output register holds, one more beat is
//   taken into the merge stage, and s_tready then drops.
//   Reset (arst_n low) empties the pipeline, idles all channels, clears
//   counts, slots, entry valid bits and the flags latch, and sets both hold
//   counts to 3. The hold registers are written on cfg_we; write them only
//   while no beat is in flight.
module power_quality_event_logger_core #(
	parameter int LOG_DEPTH  = pqel_pkg::LOG_DEPTH_DEF,
	parameter int TIME_WIDTH = pqel_pkg::TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sag_flags[2:0], swell_flags[5:3], direction_flags[13:6],
	// timestamp[45:14], query_channel[48:46], query_offset[52:49], zero pad
	input  logic [55:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// completed_mask[5:0], last_flags[19:6], query_ok[20], start_time[52:21],
	// end_time[84:53], event_count[92:85], zero pad
	output logic [95:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int NCH = pqel_pkg::NUM_CH;
	localparam int IW  = pqel_pkg::QOFF_W + 8;

	logic                            adv, acc;
	logic                            s1_valid_q;
	logic [pqel_pkg::HOLD_W-1:0]     start_hold_q, end_hold_q;
	logic [pqel_pkg::FLAGS_W-1:0]    flags_q, flags_new;
	pqel_pkg::cmd_t                  cmd;

	logic [2:0]                      sag, swell;
	logic [7:0]                      dir;
	logic [TIME_WIDTH-1:0]           ts;
	logic [pqel_pkg::QCH_W-1:0]      qch;
	logic [pqel_pkg::QOFF_W-1:0]     qoff;
	logic [NCH-1:0]                  chan_flags;
	logic                            qoff_ok;

	logic [NCH-1:0]                         lane_done, lane_ent_valid;
	logic [NCH-1:0][pqel_pkg::CNT_W-1:0]    lane_cnt;
	logic [NCH-1:0][TIME_WIDTH-1:0]         lane_cur;
	logic [NCH-1:0][2*TIME_WIDTH-1:0]       lane_rdata;

	logic [NCH-1:0]                  mg_mask;
	logic [pqel_pkg::FLAGS_W-1:0]    mg_flags;
	logic                            mg_ok;
	logic [TIME_WIDTH-1:0]           mg_start, mg_end;
	logic [pqel_pkg::CNT_W-1:0]      mg_count;

	logic                            m_valid_q;
	logic [NCH-1:0]                  mask_s2;
	logic [pqel_pkg::FLAGS_W-1:0]    flags_s2;
	logic                            ok_s2;
	logic [pqel_pkg::TS_FIELD_W-1:0] start_s2, end_s2;
	logic [pqel_pkg::CNT_W-1:0]      count_s2;

	// Unpack the input beat
	assign sag   = s_tdata[2:0];
	assign swell = s_tdata[5:3];
	assign dir   = s_tdata[13:6];
	assign ts    = TIME_WIDTH'(s_tdata[45:14]);
	assign qch   = s_tdata[48:46];
	assign qoff  = s_tdata[52:49];
	assign chan_flags = {swell, sag};
	assign qoff_ok    = (IW'(qoff) < IW'(LOG_DEPTH));

	// Handshake: the merge stage takes a beat when it is empty or moving on
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !s1_valid_q || adv;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		cmd.update     = acc && (s_tuser == pqel_pkg::KIND_UPDATE);
		cmd.clear      = acc && (s_tuser == pqel_pkg::KIND_CLEAR);
		cmd.query      = acc && (s_tuser == pqel_pkg::KIND_QUERY);
		cmd.qoff       = qoff;
		cmd.start_hold = start_hold_q;
		cmd.end_hold   = end_hold_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hold_q <= pqel_pkg::HOLD_RESET;
			end_hold_q   <= pqel_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pqel_pkg::REG_START_HOLD: start_hold_q <= cfg_data;
				pqel_pkg::REG_END_HOLD:   end_hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the direction and fault bits on update beats
	assign flags_new = cmd.update ? {swell, sag, dir} : flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q <= flags_new;
		end
	end

	// Channel lanes
	for (genvar i = 0; i < NCH; i++) begin : g_lane
		pqel_lane #(
			.LOG_DEPTH  (LOG_DEPTH),
			.TIME_WIDTH (TIME_WIDTH)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.flag      (chan_flags[i]),
			.ts        (ts),
			.sel       (qch == pqel_pkg::QCH_W'(i)),
			.done      (lane_done[i]),
			.cnt       (lane_cnt[i]),
			.cur_start (lane_cur[i]),
			.ent_valid (lane_ent_valid[i]),
			.rdata     (lane_rdata[i])
		);
	end

	pqel_merge #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_merge (
		.clk            (clk),
		.load           (acc),
		.query          (cmd.query),
		.qch            (qch),
		.qoff_zero      (qoff == '0),
		.qoff_ok        (qoff_ok),
		.lane_done      (lane_done),
		.lane_cnt       (lane_cnt),
		.lane_cur       (lane_cur),
		.lane_ent_valid (lane_ent_valid),
		.lane_rdata     (lane_rdata),
		.flags_new      (flags_new),
		.mask           (mg_mask),
		.flags          (mg_flags),
		.ok             (mg_ok),
		.start_time     (mg_start),
		.end_time       (mg_end),
		.count          (mg_count)
	);

	// Pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				m_valid_q <= s1_valid_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			mask_s2  <= mg_mask;
			flags_s2 <= mg_flags;
			ok_s2    <= mg_ok;
			start_s2 <= pqel_pkg::TS_FIELD_W'(mg_start);
			end_s2   <= pqel_pkg::TS_FIELD_W'(mg_end);
			count_s2 <= mg_count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, count_s2, end_s2, start_s2, ok_s2, flags_s2, mask_s2};

	// A waiting beat in the merge stage must block new input
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv) |-> !s_tready)
		else $error("input taken while merge stage is blocked");

	// A clear beat leaves every event count at zero
	a_clear_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (lane_cnt == '0))
		else $error("event counts not zeroed by clear");

	// A query result never reports completed events
	a_ok_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(ok_s2 && (mask_s2 != '0)))
		else $error("query result carries a completion mask");

endmodule

>>> test/power_quality_event_logger_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for power_quality_event_logger_core: a directed table, then random
// flag runs with queries and clears, scored against an in-bench channel model.
// Depends on pqel_pkg and the core RTL only.
module power_quality_event_logger_core_test;

	localparam int DEPTH = pqel_pkg::LOG_DEPTH_DEF;
	localparam int NCH   = pqel_pkg::NUM_CH;
	// Item kinds as plain two-bit codes for the stimulus table
	localparam logic [1:0] KIND_UPD = pqel_pkg::KIND_UPDATE;
	localparam logic [1:0] KIND_QRY = pqel_pkg::KIND_QUERY;
	localparam logic [1:0] KIND_CLR = pqel_pkg::KIND_CLEAR;
	// Reserved item kind: the block leaves its state alone
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  sag;
		logic [2:0]  swell;
		logic [7:0]  dir;
		logic [31:0] ts;
		logic [2:0]  qch;
		logic [3:0]  qoff;
	} pq_item_t;

	typedef struct packed {
		logic [5:0]  mask;
		logic [13:0] flags;
		logic        ok;
		logic [31:0] start_time;
		logic [31:0] end_time;
		logic [7:0]  count;
	} pq_result_t;

	typedef struct {
		pq_item_t   item;
		bit         pinned;
		pq_result_t report;
	} table_row_t;

	localparam pq_result_t NO_REPORT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	power_quality_event_logger_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Channel model state, mirrors the block after reset
	logic [7:0]        start_hold_cfg = pqel_pkg::HOLD_RESET;
	logic [7:0]        end_hold_cfg = pqel_pkg::HOLD_RESET;
	pqel_pkg::phase_t  chan_phase [NCH] = '{default: pqel_pkg::PH_IDLE};
	logic [7:0]        hold_left [NCH] = '{default: '0};
	int unsigned       slot_now [NCH] = '{default: 0};
	logic [7:0]        events_seen [NCH] = '{default: '0};
	logic [31:0]       start_times [NCH][DEPTH] = '{default: '{default: '0}};
	logic [31:0]       end_times [NCH][DEPTH] = '{default: '{default: '0}};
	logic [13:0]       flags_held = '0;

	pq_result_t  reports_due [$];
	bit          pinned_due [$];
	pq_result_t  pinned_report [$];
	int unsigned mismatch_count = 0;
	int unsigned send_gap_pct = 7;
	int unsigned recv_stall_pct = 49;

	// Directed table: reset view, extremes, holds, cancels, invalid queries, clear
	table_row_t directed_rows [25] = '{
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd0, 4'd0}, 1'b1,
			'{6'h00, 14'h0000, 1'b1, 32'h0, 32'h0, 8'h00}},
		'{'{KIND_UPD, 3'd7, 3'd7, 8'hFF, 32'hFFFF_FFFF, 3'd7, 4'd15}, 1'b1,
			'{6'h00, 14'h3FFF, 1'b0, 32'h0, 32'h0, 8'h00}},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd6, 4'd0}, 1'b1,
			'{6'h00, 14'h3FFF, 1'b0, 32'h0, 32'h0, 8'h00}},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd7, 4'd15}, 1'b1,
			'{6'h00, 14'h3FFF, 1'b0, 32'h0, 32'h0, 8'h00}},
		'{'{KIND_NONE, 3'd0, 3'd0, 8'h00, 32'h0, 3'd0, 4'd0}, 1'b1,
			'{6'h00, 14'h3FFF, 1'b0, 32'h0, 32'h0, 8'h00}},
		'{'{KIND_UPD, 3'd7, 3'd7, 8'h00, 32'd1, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd7, 3'd7, 8'h00, 32'd2, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd7, 3'd7, 8'h00, 32'd3, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd0, 3'd7, 8'h5A, 32'd10, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd1, 3'd7, 8'hA5, 32'd11, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd0, 3'd7, 8'h00, 32'd12, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd0, 3'd7, 8'h00, 32'd13, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd0, 3'd7, 8'h00, 32'd14, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd0, 3'd7, 8'h00, 32'd15, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd1, 4'd1}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd1, 4'd8}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd0, 4'd15}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd1, 3'd7, 8'h00, 32'd20, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_UPD, 3'd0, 3'd7, 8'h00, 32'd21, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd0, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd5, 4'd7}, 1'b0, NO_REPORT},
		'{'{KIND_CLR, 3'd7, 3'd7, 8'hFF, 32'hFFFF_FFFF, 3'd7, 4'd15}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd3, 4'd0}, 1'b0, NO_REPORT},
		'{'{KIND_QRY, 3'd0, 3'd0, 8'h00, 32'h0, 3'd2, 4'd1}, 1'b0, NO_REPORT}
	};

	// Step one channel machine; returns 1 when an event end is logged
	function automatic bit advance_channel(int ch, bit active, logic [31:0] ts);
		int unsigned at;
		bit ended;
		at = slot_now[ch];
		ended = 1'b0;
		case (chan_phase[ch])
			pqel_pkg::PH_IDLE: begin
				if (active) begin
					chan_phase[ch] = pqel_pkg::PH_START;
					hold_left[ch] = start_hold_cfg;
				end
			end
			pqel_pkg::PH_START: begin
				if (active) begin
					hold_left[ch] = hold_left[ch] - 8'd1;
					if (hold_left[ch] == 8'd0) begin
						start_times[ch][at] = ts;
						end_times[ch][at] = '0;
						chan_phase[ch] = pqel_pkg::PH_ACTIVE;
					end
				end else begin
					// glitch during start hold drops the pending start
					chan_phase[ch] = pqel_pkg::PH_IDLE;
					start_times[ch][at] = '0;
				end
			end
			pqel_pkg::PH_ACTIVE: begin
				if (!active) begin
					chan_phase[ch] = pqel_pkg::PH_END;
					hold_left[ch] = end_hold_cfg;
				end
			end
			default: begin
				if (active) begin
					chan_phase[ch] = pqel_pkg::PH_ACTIVE;
				end else begin
					hold_left[ch] = hold_left[ch] - 8'd1;
					if (hold_left[ch] == 8'd0) begin
						end_times[ch][at] = ts;
						slot_now[ch] = (at + 1) % DEPTH;
						start_times[ch][slot_now[ch]] = '0;
						end_times[ch][slot_now[ch]] = '0;
						events_seen[ch] = events_seen[ch] + 8'd1;
						chan_phase[ch] = pqel_pkg::PH_IDLE;
						ended = 1'b1;
					end
				end
			end
		endcase
		return ended;
	endfunction

	// Work out the report of one accepted beat and advance the model
	function automatic pq_result_t predict_report(pq_item_t it);
		pq_result_t r;
		logic [5:0] bits;
		int unsigned idx;
		r = '0;
		if (it.kind == KIND_UPD) begin
			bits = {it.swell, it.sag};
			for (int ch = 0; ch < NCH; ch++)
				r.mask[ch] = advance_channel(ch, bits[ch], it.ts);
			flags_held = {it.swell, it.sag, it.dir};
		end else if (it.kind == KIND_QRY) begin
			if (it.qch < NCH) begin
				r.count = events_seen[it.qch];
				if (it.qoff < DEPTH) begin
					idx = (slot_now[it.qch] + DEPTH - it.qoff) % DEPTH;
					r.start_time = start_times[it.qch][idx];
					r.end_time = end_times[it.qch][idx];
					r.ok = 1'b1;
				end
			end
		end else if (it.kind == KIND_CLR) begin
			for (int ch = 0; ch < NCH; ch++) begin
				chan_phase[ch] = pqel_pkg::PH_IDLE;
				hold_left[ch] = '0;
				slot_now[ch] = 0;
				events_seen[ch] = '0;
				for (int e = 0; e < DEPTH; e++) begin
					start_times[ch][e] = '0;
					end_times[ch][e] = '0;
				end
			end
		end
		r.flags = flags_held;
		return r;
	endfunction

	// Receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Score result beats, track config writes and accepted beats
	always @(posedge clk) begin
		pq_result_t got, want, model;
		pq_item_t   seen;
		bit         pin;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.mask       = m_tdata[5:0];
				got.flags      = m_tdata[19:6];
				got.ok         = m_tdata[20];
				got.start_time = m_tdata[52:21];
				got.end_time   = m_tdata[84:53];
				got.count      = m_tdata[92:85];
				if (reports_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: %h", got);
				end else begin
					want = reports_due.pop_front();
					if (got.mask !== want.mask || got.flags !== want.flags ||
							got.ok !== want.ok || got.start_time !== want.start_time ||
							got.end_time !== want.end_time || got.count !== want.count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch (exp/got): mask %h/%h flags %h/%h ok %b/%b",
								" start %h/%h end %h/%h count %h/%h"},
								want.mask, got.mask, want.flags, got.flags, want.ok, got.ok,
								want.start_time, got.start_time, want.end_time, got.end_time,
								want.count, got.count);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == pqel_pkg::REG_START_HOLD)
					start_hold_cfg = cfg_data;
				else
					end_hold_cfg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				seen = {s_tuser, s_tdata[2:0], s_tdata[5:3], s_tdata[13:6], s_tdata[45:14],
					s_tdata[48:46], s_tdata[52:49]};
				model = predict_report(seen);
				pin = pinned_due.pop_front();
				want = pinned_report.pop_front();
				reports_due.push_back(pin ? want : model);
			end
		end
	end

	// Offer one beat, with random idle cycles ahead of it, and hold until taken
	task automatic send_item(pq_item_t it, bit pinned, pq_result_t report);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		pinned_due.push_back(pinned);
		pinned_report.push_back(report);
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {3'b000, it.qoff, it.qch, it.ts, it.dir, it.swell, it.sag};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every report has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_hold_counts(logic [7:0] start_val, logic [7:0] end_val);
		cfg_we <= 1'b1;
		cfg_index <= pqel_pkg::REG_START_HOLD;
		cfg_data <= start_val;
		@(posedge clk);
		cfg_index <= pqel_pkg::REG_END_HOLD;
		cfg_data <= end_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random traffic: mostly held flag patterns long enough to qualify,
	// with glitches, noise, queries and the odd clear mixed in
	task automatic run_random(int unsigned n_items);
		int unsigned sent, run_left, span, roll, longest;
		logic [5:0] pattern, bits;
		pq_item_t it;
		sent = 0;
		run_left = 0;
		pattern = '0;
		longest = (start_hold_cfg == 8'd0) ? 256 : int'(start_hold_cfg);
		if (end_hold_cfg == 8'd0)
			longest = 256;
		else if (int'(end_hold_cfg) > longest)
			longest = int'(end_hold_cfg);
		span = longest + longest / 2 + 3;
		while (sent < n_items) begin
			it.dir = 8'($urandom);
			it.ts = $urandom;
			it.qch = 3'(($urandom_range(99) < 85) ? $urandom_range(5) : $urandom_range(7, 6));
			it.qoff = 4'(($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(15, 8));
			bits = 6'($urandom);
			roll = $urandom_range(999);
			if (roll < 5) begin
				it.kind = KIND_NONE;
			end else if (roll < 10) begin
				it.kind = KIND_CLR;
			end else if (roll < 170) begin
				it.kind = KIND_QRY;
			end else begin
				it.kind = KIND_UPD;
				if (run_left == 0) begin
					pattern = 6'($urandom);
					run_left = $urandom_range(span, 1);
				end
				run_left--;
				if ($urandom_range(99) >= 3) begin
					bits = pattern;
					// single-update glitch on one channel
					if ($urandom_range(99) < 4)
						bits[$urandom_range(5)] ^= 1'b1;
				end
			end
			it.sag = bits[2:0];
			it.swell = bits[5:3];
			send_item(it, 1'b0, NO_REPORT);
			if (it.kind != KIND_NONE)
				sent++;
		end
	endtask

	task automatic run_phase(logic [7:0] start_val, logic [7:0] end_val,
			int unsigned gap, int unsigned stall, int unsigned n_items);
		drain();
		write_hold_counts(start_val, end_val);
		send_gap_pct = gap;
		recv_stall_pct = stall;
		run_random(n_items);
	endtask

	// Main sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].report);
		run_phase(8'd1, 8'd1, 7, 49, 330);
		run_phase(8'd4, 8'd2, 49, 7, 330);
		run_phase(8'd255, 8'd0, 0, 0, 330);
		run_phase(8'd0, 8'd1, 0, 0, 310);
		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
src/pqel_pkg.sv
src/pqel_ram.sv
src/pqel_lane.sv
src/pqel_merge.sv
src/power_quality_event_logger_core.sv
test/power_quality_event_logger_core_test.sv
